// File: hdl/sida_pkg.sv
// Package for the signed integer to decimal ASCII core.
// Holds the shared widths, character codes, sequencer states and the converter response type.
// No dependencies.
`timescale 1ns / 1ps

package sida_pkg;

	localparam int BIN_W   = 16;
	localparam int DIGITS  = 5;
	localparam int BCD_W   = DIGITS * 4;
	localparam int CNT_W   = 5;
	localparam int IDX_W   = 3;
	localparam int CHAR_W  = 7;

	localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHR_MINUS = 7'd45;
	localparam logic [CHAR_W-1:0] CHR_NINE  = 7'd57;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGIT
	} sida_state_t;

	// Response of the shift-add-3 converter: a one-cycle done pulse with the packed BCD digits.
	typedef struct packed {
		logic             done;
		logic [BCD_W-1:0] bcd;
	} sida_dbl_rsp_t;

endpackage

// File: hdl/sida_dabble.sv
// Iterative binary to BCD converter (shift-add-3), one bit per cycle.
// Depends on sida_pkg.
`timescale 1ns / 1ps

module sida_dabble
	import sida_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [BIN_W-1:0]  bin,
	output sida_dbl_rsp_t     rsp
);

	logic [BCD_W+BIN_W-1:0] sh_q;
	logic [BCD_W+BIN_W-1:0] sh_adj;
	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;
	logic                   done_q;

	// Every BCD digit of five or more gets three added before the shift.
	always_comb begin
		sh_adj = sh_q;
		for (int i = 0; i < DIGITS; i++) begin
			if (sh_q[BIN_W + i*4 +: 4] >= 4'd5) begin
				sh_adj[BIN_W + i*4 +: 4] = sh_q[BIN_W + i*4 +: 4] + 4'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(BIN_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sh_q <= {{BCD_W{1'b0}}, bin};
		end else if (run_q) begin
			sh_q <= {sh_adj[BCD_W+BIN_W-2:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.bcd  = sh_q[BCD_W+BIN_W-1:BIN_W];

`ifndef SYNTHESIS
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(run_q))
		else $error("converter finished without running");
	a_no_go_while_run: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> !go)
		else $error("converter restarted while running");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> (cnt_q != '0))
		else $error("converter running with empty bit count");
`endif

endmodule

// File: hdl/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 16-bit integer to decimal ASCII core.
// Depends on sida_pkg and sida_dabble.
`timescale 1ns / 1ps
//
// Channel  | Ports                          | Handshake
// ---------+--------------------------------+----------------------------------------
// command  | start, busy, value[15:0]       | item taken on a clock edge with start=1, busy=0
// result   | char_strobe, char_code[6:0],   | one item per cycle with char_strobe=1,
//          | last_char                      | taken at the end of that cycle
//
// One input item yields 1 to 6 characters; busy falls as the last of them is presented.
// The shift-add-3 converter takes the input bits one at a time, the leading digit is
// then found as its result is registered, and each character then leaves through the
// output register.
// The reset is asynchronous and active low and returns the sequencer to idle with no
// character strobe. The receiver cannot stall; characters are produced back to back.

module signed_int_to_decimal_ascii_core
	import sida_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [BIN_W-1:0]  value,
	output logic              char_strobe,
	output logic [CHAR_W-1:0] char_code,
	output logic              last_char
);

	sida_state_t       state_q, state_d;
	sida_dbl_rsp_t     dbl_rsp;
	logic              accept;
	logic              neg_q;
	logic [BIN_W-1:0]  mag;
	logic [BCD_W-1:0]  bcd_q, bcd_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [IDX_W-1:0]  lead;
	logic [3:0]        cur_digit;
	logic              strobe_q, strobe_d;
	logic [CHAR_W-1:0] code_q, code_d;
	logic              last_q, last_d;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// The magnitude is taken modulo 2^16, so the most negative value gives 32768 exactly.
	assign mag = value[BIN_W-1] ? (BIN_W'(0) - value) : value;

	sida_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.bin    (mag),
		.rsp    (dbl_rsp)
	);

	// Highest non-zero digit; an all-zero result leaves the units digit, which prints '0'.
	always_comb begin
		lead = '0;
		for (int i = 1; i < DIGITS; i++) begin
			if (dbl_rsp.bcd[i*4 +: 4] != 4'd0) begin
				lead = IDX_W'(i);
			end
		end
	end

	assign cur_digit = bcd_q[idx_q*4 +: 4];

	always_comb begin
		state_d  = state_q;
		bcd_d    = bcd_q;
		idx_d    = idx_q;
		strobe_d = 1'b0;
		code_d   = code_q;
		last_d   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				if (dbl_rsp.done) begin
					bcd_d   = dbl_rsp.bcd;
					idx_d   = lead;
					state_d = neg_q ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				strobe_d = 1'b1;
				code_d   = CHR_MINUS;
				state_d  = ST_DIGIT;
			end
			ST_DIGIT: begin
				strobe_d = 1'b1;
				code_d   = CHR_ZERO + CHAR_W'(cur_digit);
				last_d   = (idx_q == '0);
				if (idx_q == '0) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q - 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value[BIN_W-1];
		end
		bcd_q  <= bcd_d;
		idx_q  <= idx_d;
		code_q <= code_d;
		last_q <= last_d;
	end

	assign char_strobe = strobe_q;
	assign char_code   = code_q;
	assign last_char   = last_q;

`ifndef SYNTHESIS
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		char_strobe |-> (char_code == CHR_MINUS)
			|| ((char_code >= CHR_ZERO) && (char_code <= CHR_NINE)))
		else $error("character outside the minus sign and digits");
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_strobe && (char_code == CHR_MINUS)) |-> !last_char)
		else $error("minus sign marked as the final character");
	a_done_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		dbl_rsp.done |-> (state_q == ST_CONV))
		else $error("converter finished outside the conversion phase");
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(char_strobe && last_char) |-> !busy || $past(accept))
		else $error("final character while the item is still in progress");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy did not rise after an item was taken");
`endif

endmodule

// File: sim/tb.sv
// Self-checking testbench for signed_int_to_decimal_ascii_core.
// Predicts the ASCII text of each number and checks every character as it leaves the block.
// Depends on sida_pkg and the core's RTL.
`timescale 1ns / 1ps

module tb;
	import sida_pkg::*;

	localparam int RADIX       = 10;
	localparam int QUIET_LIMIT = 1000;
	localparam int TAIL_CYCLES = 30;
	localparam int REPORT_MAX  = 10;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
	} ascii_char_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [BIN_W-1:0]  value;
	logic              char_strobe;
	logic [CHAR_W-1:0] char_code;
	logic              last_char;

	ascii_char_t expected_chars [$];

	int mismatches     = 0;
	int numbers_sent   = 0;
	int negatives_sent = 0;
	int chars_checked  = 0;
	int quiet_cycles   = 0;
	int gap_max        = 13;
	int free_pct       = 30;
	bit len_seen [1:6];

	signed_int_to_decimal_ascii_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.char_strobe (char_strobe),
		.char_code   (char_code),
		.last_char   (last_char)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Appends the characters that one number should produce: an optional minus sign, then
	// the digits from the most significant one, with leading zeros dropped.
	function automatic void predict_decimal_text(input logic [BIN_W-1:0] v);
		logic [BIN_W:0] mag;
		int             digit [DIGITS];
		int             n;
		int             j;
		ascii_char_t    ch;
		mag = v[BIN_W-1] ? ({1'b1, {BIN_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
		n = 0;
		if (mag == 0) begin
			ch.code = CHR_ZERO;
			ch.last = 1'b1;
			expected_chars.push_back(ch);
			len_seen[1] = 1'b1;
		end else begin
			while (mag != 0 && n < DIGITS) begin
				digit[n] = int'(mag % RADIX);
				mag = mag / RADIX;
				n++;
			end
			if (v[BIN_W-1]) begin
				ch.code = CHR_MINUS;
				ch.last = 1'b0;
				expected_chars.push_back(ch);
			end
			for (j = n - 1; j >= 0; j--) begin
				ch.code = CHR_ZERO + CHAR_W'(digit[j]);
				ch.last = (j == 0);
				expected_chars.push_back(ch);
			end
			len_seen[n + int'(v[BIN_W-1])] = 1'b1;
		end
	endfunction

	// Mostly numbers of a chosen digit count and sign, so that every text length comes up
	// often; the rest are raw 16-bit patterns, the extremes, -1 and zero.
	function automatic logic [BIN_W-1:0] random_number();
		int               len;
		int               lo;
		int               hi;
		int               mag;
		bit               neg;
		logic [BIN_W-1:0] r;
		len = $urandom_range(0, 6);
		neg = 1'($urandom_range(0, 1));
		if (len == 0) begin
			r = BIN_W'($urandom);
		end else if (len == 6) begin
			case ($urandom_range(0, 3))
				0: r = 16'h8000;
				1: r = 16'h7FFF;
				2: r = 16'hFFFF;
				default: r = 16'h0000;
			endcase
		end else begin
			lo = 1;
			repeat (len - 1) lo = lo * RADIX;
			hi = lo * RADIX - 1;
			if (len == 1)
				lo = 0;
			if (hi > 32767)
				hi = neg ? 32768 : 32767;
			mag = $urandom_range(lo, hi);
			r = neg ? BIN_W'(-mag) : BIN_W'(mag);
		end
		return r;
	endfunction

	// Offers one number and returns at the clock edge on which the block takes it. Start is
	// left high there; whatever runs next in the same time step lowers or reuses it.
	task automatic send_number(input logic [BIN_W-1:0] v);
		int gap;
		bit wait_free;
		gap = $urandom_range(0, gap_max);
		wait_free = ($urandom_range(0, 99) < free_pct);
		if (wait_free) begin
			start <= 1'b0;
			value <= BIN_W'($urandom);
			@(posedge clk);
			while (busy)
				@(posedge clk);
			repeat (gap) @(posedge clk);
		end else if (gap > 0) begin
			start <= 1'b0;
			value <= BIN_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
		predict_decimal_text(v);
		numbers_sent++;
		if (v[BIN_W-1])
			negatives_sent++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_chars.size() != 0);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("Mismatch at %0t ns: %s", $time, msg);
	endtask

	// Character checker and watchdog.
	always @(posedge clk) begin
		ascii_char_t want;
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((start && !busy) || char_strobe)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (char_strobe) begin
				chars_checked++;
				if (expected_chars.size() == 0) begin
					note_mismatch($sformatf("unexpected character code %0d last %0b",
						char_code, last_char));
				end else begin
					want = expected_chars.pop_front();
					if (char_code !== want.code || last_char !== want.last)
						note_mismatch($sformatf(
							"expected code %0d last %0b, got code %0d last %0b",
							want.code, want.last, char_code, last_char));
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: nothing moved for %0d cycles", quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Zero, single digits, every change of digit count, both extremes and alternating bits.
	task automatic test_directed();
		logic [BIN_W-1:0] corner [22] = '{
			16'd0, 16'd1, -16'sd1, 16'd9, -16'sd9, 16'd10, -16'sd10, 16'd99, -16'sd100,
			16'd100, 16'd999, 16'd1000, 16'd9999, 16'd10000, -16'sd10000, 16'd32767,
			-16'sd32767, 16'h8000, 16'd12345, -16'sd23456, 16'h5555, 16'hAAAA
		};
		foreach (corner[i])
			send_number(corner[i]);
	endtask

	// The sender stops until every character has come out before going on.
	task automatic test_drained_pause();
		repeat (4) send_number(random_number());
		drain_results();
		send_number(16'h8000);
		drain_results();
	endtask

	task automatic test_back_to_back();
		gap_max = 0;
		free_pct = 0;
		repeat (15) send_number(random_number());
		gap_max = 13;
		free_pct = 30;
	endtask

	task automatic test_random();
		repeat (125) send_number(random_number());
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_drained_pause();
		test_back_to_back();
		test_random();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Converted %0d numbers (%0d negative), checked %0d characters, %0d mismatches.",
			numbers_sent, negatives_sent, chars_checked, mismatches);
		$display("Text lengths seen (1..6 characters): %0b%0b%0b%0b%0b%0b",
			len_seen[1], len_seen[2], len_seen[3], len_seen[4], len_seen[5], len_seen[6]);
		if (expected_chars.size() != 0)
			$display("%0d characters never arrived", expected_chars.size());
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
